// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file stal_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/stal_pkg.sv -----
// ----------------------------------------------------------------------------
// stal_pkg
// Types and constants of the slot table: table geometry, request and
// response transfers, status codes and the RAM port bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package stal_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ID_BITS     = 16;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (ID_BITS > 16) ? ID_BITS : 16;

	localparam logic REQ_ADMIT  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [1:0] RES_OK        = 2'd0;
	localparam logic [1:0] RES_FULL      = 2'd1;
	localparam logic [1:0] RES_NOT_FOUND = 2'd2;
	localparam logic [1:0] RES_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [15:0] vehicle_id;
		logic [15:0] search_id;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_index;
		logic [15:0] assigned_id;
	} rsp_item_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [15:0]        vehicle;
	} entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic [IDX_W-1:0] rd_addr;
	} ram_req_t;

endpackage

`default_nettype wire

// ----- hdl/slot_table_admit_and_lookup.sv -----
// ----------------------------------------------------------------------------
// slot_table_admit_and_lookup
// Slot table with first-free admission and lookup by admission id.
//
// Request channel req (req_valid/req_ready) carries an admit or a lookup;
// response channel rsp (rsp_valid/rsp_ready) returns one result per request.
// Slots fill in order, so a fill count marks the free slot and the valid
// range of the entry RAM; no clearing pass runs after reset.
// Admit: the result is registered in the engine, then in the output register.
// Lookup: the engine scans the filled slots of the entry RAM, one per cycle
// from slot 0, and stops at the first match or the last filled slot; with an
// empty table it skips the scan. The result then goes to the output register.
// One request is in work at a time; req_ready rises again once its result
// moves into the output register.
// Reset empties the table, clears the highest id and drops any pending result.
// When the receiver stalls, the output register holds its result and one more
// request may be taken and worked; its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_table_admit_and_lookup import stal_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp
);

	ram_req_t  ram;
	entry_t    rd_data;
	rsp_item_t res;
	logic      res_valid;
	logic      res_ready;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	stal_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.ram       (ram),
		.rd_data   (rd_data),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	stal_ram u_ram (
		.clk     (clk),
		.ram     (ram),
		.rd_data (rd_data)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/stal_ram.sv -----
// ----------------------------------------------------------------------------
// stal_ram
// Slot entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stal_ram import stal_pkg::*; (
	input  wire logic     clk,
	input  wire ram_req_t ram,
	output entry_t        rd_data
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (ram.wr_en) begin
			mem[ram.wr_addr] <= ram.wr_data;
		end
		rd_data <= mem[ram.rd_addr];
	end

endmodule

`default_nettype wire

// ----- hdl/stal_engine.sv -----
// ----------------------------------------------------------------------------
// stal_engine
// Request sequencer: admits into the next slot of the fill count and scans
// the filled slots one per cycle for a lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module stal_engine import stal_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire req_item_t req,
	input  wire logic      req_valid,
	output logic           req_ready,
	output ram_req_t       ram,
	input  wire entry_t    rd_data,
	output rsp_item_t      res,
	output logic           res_valid,
	input  wire logic      res_ready
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [ID_BITS-1:0] highest_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [CMP_W-1:0]   key_q;
	rsp_item_t          res_q;

	logic               acc;
	logic               full;
	logic               exhausted;
	logic               admit_ok;
	logic               last;
	logic               hit;
	logic [ID_BITS-1:0] new_id;

	always_comb begin
		req_ready = (state_q == S_IDLE);
		acc       = req_valid && req_ready;
		full      = (count_q == CNT_W'(TABLE_DEPTH));
		exhausted = (highest_q == '1);
		new_id    = highest_q + 1'b1;
		admit_ok  = acc && (req.req_type == REQ_ADMIT) && !full && !exhausted;
		last      = (ptr_q == IDX_W'(count_q - 1'b1));
		hit       = (CMP_W'(rd_data.id) == key_q);

		ram.wr_en   = admit_ok;
		ram.wr_addr = IDX_W'(count_q);
		ram.wr_data = '{id: new_id, vehicle: req.vehicle_id};
		ram.rd_addr = (state_q == S_IDLE) ? '0 : ptr_q + 1'b1;

		res       = res_q;
		res_valid = (state_q == S_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			highest_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (req.req_type == REQ_ADMIT) begin
							state_q <= S_EMIT;
						end else if (count_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
					if (admit_ok) begin
						count_q   <= count_q + 1'b1;
						highest_q <= new_id;
					end
				end
				S_SCAN: begin
					if (hit || last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			key_q <= CMP_W'(req.search_id);
			ptr_q <= '0;
			if (req.req_type == REQ_LOOKUP) begin
				res_q <= '{status: RES_NOT_FOUND, slot_index: '0, assigned_id: '0};
			end else if (full) begin
				res_q <= '{status: RES_FULL, slot_index: '0, assigned_id: '0};
			end else if (exhausted) begin
				res_q <= '{status: RES_EXHAUSTED, slot_index: '0, assigned_id: '0};
			end else begin
				res_q <= '{status: RES_OK, slot_index: 6'(count_q),
					assigned_id: 16'(new_id)};
			end
		end else if (state_q == S_SCAN) begin
			if (hit) begin
				res_q <= '{status: RES_OK, slot_index: 6'(ptr_q),
					assigned_id: 16'(rd_data.id)};
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/stal_checker.sv -----
// ----------------------------------------------------------------------------
// stal_checker
// Port-level checks of the slot table: request and response hold, field
// rules of failed results and request/response accounting.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stal_checker import stal_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_ready,
	input wire req_item_t req,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire rsp_item_t rsp
);

	logic [1:0] pending_q;
	logic       req_xfer;
	logic       rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_xfer && !rsp_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (rsp_xfer && !req_xfer) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && !req_ready, req_valid && $stable(req))
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`ASSERT_IMPL(a_fail_zero, clk, arst_n, rsp_valid && (rsp.status != RES_OK), (rsp.slot_index == '0) && (rsp.assigned_id == '0))
	`ASSERT_IMPL(a_no_orphan, clk, arst_n, rsp_valid, pending_q != 2'd0)
	`ASSERT_IMPL(a_pending_cap, clk, arst_n, 1'b1, pending_q != 2'd3)

endmodule

bind slot_table_admit_and_lookup stal_checker u_stal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
